### rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared constants for the trial division prime test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

	// width of the number field on the request channel
	localparam int NUMBER_W = 32;

	// default working width of the number
	localparam int NUM_WIDTH_DEF = 32;

	// first odd divisor and the step between divisors
	localparam int FIRST_DIVISOR = 3;
	localparam int DIVISOR_STEP  = 2;

endpackage

`default_nettype wire

### rtl/tdpt_num_if.sv
// ----------------------------------------------------------------------------
// tdpt_num_if
// request channel carrying the number under test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_num_if;
	import tdpt_pkg::*;

	logic                valid;
	logic                ready;
	logic [NUMBER_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);

endinterface

`default_nettype wire

### rtl/tdpt_res_if.sv
// ----------------------------------------------------------------------------
// tdpt_res_if
// response channel carrying the primality verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_res_if;

	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);

endinterface

`default_nettype wire

### rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality test by trial division over odd divisors on a bit-serial divider
// ----------------------------------------------------------------------------
//  channel  dir  payload          transaction
//  req      in   number[31:0]     valid & ready at rising clk
//  rsp      out  is_prime         valid & ready at rising clk
//
//  zero, one, two, three and even numbers go from idle straight to finish
//  otherwise each odd divisor 3, 5, ... takes a full pass of the restoring
//  divider and an evaluation step, up to about sqrt(n)/2 divisors
//  arst_n clears the sequencer and the response valid flag; no memory to sweep
//  req.ready is high only while idle; a held response stalls the next finish
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test #(
	parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	tdpt_num_if.sink   req,
	tdpt_res_if.source rsp
);
	import tdpt_pkg::*;

	localparam int W     = NUM_WIDTH;
	localparam int CNT_W = $clog2(NUM_WIDTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_EVAL   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     n_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     sh_q;
	logic [W-1:0]     r_q;
	logic             res_q;
	logic             rsp_valid_q;
	logic             is_prime_q;

	logic [W-1:0] n_in;
	logic         in_fire;
	logic         out_free;
	logic         in_small;
	logic         in_tiny;
	logic         in_even;
	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         qbit;
	logic         div_last;

	assign n_in     = W'(req.number);
	assign in_fire  = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign in_tiny  = n_in < W'(2);
	assign in_small = n_in < W'(4);
	assign in_even  = !n_in[0];

	// restoring divider step
	assign trial    = {r_q, sh_q[W-1]};
	assign diff     = trial - {1'b0, d_q};
	assign qbit     = !diff[W];
	assign div_last = cnt_q == CNT_W'(W - 1);

	assign req.ready    = state_q == ST_IDLE;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.is_prime = is_prime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_FINISH) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						if (in_small || in_even) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_EVAL;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_EVAL: begin
					if (d_q > sh_q || r_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					n_q   <= n_in;
					sh_q  <= n_in;
					r_q   <= '0;
					d_q   <= W'(FIRST_DIVISOR);
					res_q <= !in_tiny && (in_small || !in_even);
				end
			end
			ST_DIV: begin
				sh_q <= {sh_q[W-2:0], qbit};
				r_q  <= qbit ? diff[W-1:0] : trial[W-1:0];
			end
			ST_EVAL: begin
				// sh_q holds the quotient, r_q the remainder
				if (d_q > sh_q) begin
					res_q <= 1'b1;
				end else if (r_q == '0) begin
					res_q <= 1'b0;
				end else begin
					d_q  <= d_q + W'(DIVISOR_STEP);
					sh_q <= n_q;
					r_q  <= '0;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					is_prime_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_div_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> d_q[0] && d_q >= W'(FIRST_DIVISOR))
		else $error("divisor not odd or below three");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> r_q < d_q)
		else $error("partial remainder not below divisor");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("response raised outside finish");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=> rsp_valid_q && $stable(is_prime_q))
		else $error("pending response lost or changed");

	a_eval_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> $past(state_q) == ST_DIV)
		else $error("evaluation without a finished division");

endmodule

`default_nettype wire
